// ===== design/sha1md_pkg.sv =====
`timescale 1ns / 1ps

package sha1md_pkg;

    // digest geometry
    localparam int NUM_WORDS  = 5;
    localparam int NUM_ROUNDS = 80;
    localparam int SCHED_MEM  = 16;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round constants
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // chaining start values
    localparam logic [31:0] H_0 = 32'h67452301;
    localparam logic [31:0] H_1 = 32'hEFCDAB89;
    localparam logic [31:0] H_2 = 32'h98BADCFE;
    localparam logic [31:0] H_3 = 32'h10325476;
    localparam logic [31:0] H_4 = 32'hC3D2E1F0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    // control from the sequencer to the message buffer
    typedef struct packed {
        logic       we;
        logic [5:0] waddr;
        logic [7:0] wdata;
        logic       rd_en;
        logic [3:0] rd_addr;
        logic       use_mem;
        logic       shift_en;
    } t_msg_ctl;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = H_0;
            3'd1:    v = H_1;
            3'd2:    v = H_2;
            3'd3:    v = H_3;
            3'd4:    v = H_4;
            default: v = H_0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/sha1md_msg.sv =====
`timescale 1ns / 1ps

module sha1md_msg (
    input  logic                  i_clk,
    input  sha1md_pkg::t_msg_ctl  i_ctl,
    output logic [31:0]           o_w
);

    // block buffer, big-endian bytes inside each word
    logic [31:0] mem [sha1md_pkg::SCHED_MEM];
    logic [31:0] r_q;

    // last sixteen schedule words, r_w[15] is the newest
    logic [31:0] r_w [16];
    logic [31:0] w_mix;
    logic [31:0] w_exp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_ctl.waddr[5:2]][{~i_ctl.waddr[1:0], 3'b000} +: 8] <= i_ctl.wdata;
        end
        if (i_ctl.rd_en) begin
            r_q <= mem[i_ctl.rd_addr];
        end
    end

    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_exp = {w_mix[30:0], w_mix[31]};
    assign o_w   = i_ctl.use_mem ? r_q : w_exp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= o_w;
        end
    end

endmodule

// ===== design/sha1_message_digest_core.sv =====
`timescale 1ns / 1ps

// SHA-1 digest of a byte stream. One request carries at most one message byte plus an
// end-of-message mark; a request with no byte and the mark closes the message as it stands,
// including the empty message. A closing request yields five 32-bit digest words, most
// significant first, tagged with their index, after which the core starts a fresh message on
// its own. Bytes are taken one per cycle while the core is idle. Every 64th byte starts a
// compression (fetch the chaining words, 80 rounds on the single round unit, add back into
// the chaining memory), during which o_stall is high. A close writes the padding one byte
// per cycle through the same byte-wide buffer port (up to 64 bytes, 72 when an extra block
// is needed) with one or two compressions, then delivers the five words one at a time, each
// fetched only once the output register is free. The next message may be requested as soon
// as o_stall drops, while the last digest word may still sit in the output register.

module sha1_message_digest_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [6:0] LAST_ROUND = 7'(sha1md_pkg::NUM_ROUNDS - 1);
    localparam logic [6:0] WORD_STEPS = 7'(sha1md_pkg::NUM_WORDS);
    localparam logic [2:0] LAST_IDX   = 3'(sha1md_pkg::NUM_WORDS - 1);

    // sequencer state
    sha1md_pkg::t_state r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_close, n_close;          // end mark seen for this message
    logic        r_pad_first, n_pad_first;  // 0x80 not yet written
    logic        r_len_ok, n_len_ok;        // length bytes go in this block
    logic        r_final, n_final;          // running compression is the last one

    // working variables a..e
    logic [31:0] r_wa, r_wb, r_wc, r_wd, r_we;
    logic [31:0] n_wa, n_wb, n_wc, n_wd, n_we;

    // chaining memory, entries read as the start values until written
    logic [31:0] chain_mem [sha1md_pkg::NUM_WORDS];
    logic [4:0]  r_chain_vld, n_chain_vld;
    logic [31:0] r_chain_q;
    logic [2:0]  r_chain_q_addr;
    logic        r_chain_q_vld;
    logic [31:0] chain_data;
    logic        chain_rd_en;
    logic [2:0]  chain_rd_addr;
    logic        chain_we;
    logic [2:0]  chain_waddr;
    logic [31:0] chain_wdata;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_out_pend, n_out_pend;
    logic [2:0]  r_pend_idx, n_pend_idx;
    logic        out_acc;
    logic        in_acc;

    // round datapath
    sha1md_pkg::t_msg_ctl msg_ctl;
    logic [31:0] w_t;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_sum;
    logic [7:0]  len_byte;

    sha1md_msg u_msg (
        .i_clk (i_clk),
        .i_ctl (msg_ctl),
        .o_w   (w_t)
    );

    assign o_stall       = (r_state != sha1md_pkg::ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == LAST_IDX);

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;

    assign chain_data = r_chain_q_vld ? r_chain_q : sha1md_pkg::init_word(r_chain_q_addr);

    // length byte for buffer positions 56..63, most significant first
    assign len_byte = r_bits[{~r_fill[2:0], 3'b000} +: 8];

    // round function and constant by round group
    always_comb begin
        if (r_cnt < 7'd20) begin
            f_val = (r_wb & r_wc) | (~r_wb & r_wd);
            k_val = sha1md_pkg::K_0;
        end else if (r_cnt < 7'd40) begin
            f_val = r_wb ^ r_wc ^ r_wd;
            k_val = sha1md_pkg::K_1;
        end else if (r_cnt < 7'd60) begin
            f_val = (r_wb & r_wc) | (r_wb & r_wd) | (r_wc & r_wd);
            k_val = sha1md_pkg::K_2;
        end else begin
            f_val = r_wb ^ r_wc ^ r_wd;
            k_val = sha1md_pkg::K_3;
        end
    end

    assign t_sum = {r_wa[26:0], r_wa[31:27]} + f_val + r_we + k_val + w_t;

    // chaining memory, one write and one read port
    always_ff @(posedge i_clk) begin
        if (chain_we) begin
            chain_mem[chain_waddr] <= chain_wdata;
        end
        if (chain_rd_en) begin
            r_chain_q      <= chain_mem[chain_rd_addr];
            r_chain_q_addr <= chain_rd_addr;
            r_chain_q_vld  <= r_chain_vld[chain_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1md_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_bits      <= '0;
            r_close     <= 1'b0;
            r_pad_first <= 1'b1;
            r_len_ok    <= 1'b0;
            r_final     <= 1'b0;
            r_chain_vld <= '0;
            r_out_valid <= 1'b0;
            r_out_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_bits      <= n_bits;
            r_close     <= n_close;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_final     <= n_final;
            r_chain_vld <= n_chain_vld;
            r_out_valid <= n_out_valid;
            r_out_pend  <= n_out_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wa       <= n_wa;
        r_wb       <= n_wb;
        r_wc       <= n_wc;
        r_wd       <= n_wd;
        r_we       <= n_we;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_pend_idx <= n_pend_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_close     = r_close;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_final     = r_final;
        n_wa        = r_wa;
        n_wb        = r_wb;
        n_wc        = r_wc;
        n_wd        = r_wd;
        n_we        = r_we;
        n_chain_vld = r_chain_vld;
        n_out_valid = r_out_valid && !out_acc;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_pend  = 1'b0;
        n_pend_idx  = r_pend_idx;

        chain_rd_en   = 1'b0;
        chain_rd_addr = r_cnt[2:0];
        chain_we      = 1'b0;
        chain_waddr   = r_cnt[2:0] - 3'd1;
        chain_wdata   = chain_data + r_wa;

        msg_ctl          = '0;
        msg_ctl.waddr    = r_fill;
        msg_ctl.wdata    = i_data_byte;
        msg_ctl.rd_addr  = r_cnt[3:0] + 4'd1;

        case (r_state)
            sha1md_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_has_byte) begin
                        msg_ctl.we = 1'b1;
                        n_fill     = r_fill + 6'd1;
                        n_bits     = r_bits + 64'd8;
                        n_close    = i_last_byte;
                        if (r_fill == 6'd63) begin
                            // block full: compress before padding, if any
                            n_state = sha1md_pkg::ST_LOAD;
                            n_cnt   = '0;
                        end else if (i_last_byte) begin
                            n_state = sha1md_pkg::ST_PAD;
                        end
                    end else if (i_last_byte) begin
                        // empty close
                        n_close = 1'b1;
                        n_state = sha1md_pkg::ST_PAD;
                    end
                end
            end

            sha1md_pkg::ST_PAD: begin
                msg_ctl.we = 1'b1;
                n_fill     = r_fill + 6'd1;
                if (r_pad_first) begin
                    msg_ctl.wdata = sha1md_pkg::PAD_BYTE;
                    n_pad_first   = 1'b0;
                    n_len_ok      = (r_fill[5:3] != 3'd7);
                end else if (r_len_ok && r_fill[5:3] == 3'd7) begin
                    msg_ctl.wdata = len_byte;
                end else begin
                    msg_ctl.wdata = 8'h00;
                end
                if (r_fill == 6'd63) begin
                    n_final = !r_pad_first && r_len_ok;
                    n_state = sha1md_pkg::ST_LOAD;
                    n_cnt   = '0;
                end
            end

            sha1md_pkg::ST_LOAD: begin
                // fetch chaining words into a..e, then the first buffer word
                chain_rd_en = (r_cnt < WORD_STEPS);
                if (r_cnt != 7'd0) begin
                    n_wa = r_wb;
                    n_wb = r_wc;
                    n_wc = r_wd;
                    n_wd = r_we;
                    n_we = chain_data;
                end
                if (r_cnt == WORD_STEPS) begin
                    msg_ctl.rd_en   = 1'b1;
                    msg_ctl.rd_addr = '0;
                    n_state         = sha1md_pkg::ST_ROUND;
                    n_cnt           = '0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end

            sha1md_pkg::ST_ROUND: begin
                msg_ctl.use_mem  = (r_cnt < 7'(sha1md_pkg::SCHED_MEM));
                msg_ctl.rd_en    = (r_cnt < 7'(sha1md_pkg::SCHED_MEM - 1));
                msg_ctl.shift_en = 1'b1;
                n_wa = t_sum;
                n_wb = r_wa;
                n_wc = {r_wb[1:0], r_wb[31:2]};
                n_wd = r_wc;
                n_we = r_wd;
                if (r_cnt == LAST_ROUND) begin
                    n_state = sha1md_pkg::ST_ADD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end

            sha1md_pkg::ST_ADD: begin
                // read word j while writing back word j-1, a..e rotate each write
                chain_rd_en = (r_cnt < WORD_STEPS);
                if (r_cnt != 7'd0) begin
                    chain_we                 = 1'b1;
                    n_chain_vld[chain_waddr] = 1'b1;
                    n_wa = r_wb;
                    n_wb = r_wc;
                    n_wc = r_wd;
                    n_wd = r_we;
                    n_we = r_wa;
                end
                if (r_cnt == WORD_STEPS) begin
                    n_cnt = '0;
                    if (r_final) begin
                        n_state = sha1md_pkg::ST_OUT;
                    end else if (r_close) begin
                        // padding continues, extra block carries the length
                        n_state = sha1md_pkg::ST_PAD;
                        if (!r_pad_first) begin
                            n_len_ok = 1'b1;
                        end
                    end else begin
                        n_state = sha1md_pkg::ST_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end

            sha1md_pkg::ST_OUT: begin
                if (r_out_pend) begin
                    n_out_valid = 1'b1;
                    n_out_word  = chain_data;
                    n_out_idx   = r_pend_idx;
                    if (r_pend_idx == LAST_IDX) begin
                        // digest out: back to the start values
                        n_state     = sha1md_pkg::ST_IDLE;
                        n_cnt       = '0;
                        n_fill      = '0;
                        n_bits      = '0;
                        n_close     = 1'b0;
                        n_pad_first = 1'b1;
                        n_len_ok    = 1'b0;
                        n_final     = 1'b0;
                        n_chain_vld = '0;
                    end
                end else if (r_cnt < WORD_STEPS && (!r_out_valid || out_acc)) begin
                    chain_rd_en = 1'b1;
                    n_out_pend  = 1'b1;
                    n_pend_idx  = r_cnt[2:0];
                    n_cnt       = r_cnt + 7'd1;
                end
            end

            default: begin
                n_state = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    // a digest word lands only in an empty output register
    a_out_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_pend |-> !r_out_valid
    ) else $error("digest word loaded over an unconsumed word");

    // read-modify-write on the chaining memory never hits one entry twice in a cycle
    a_chain_no_collide: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (chain_we && chain_rd_en) |-> (chain_waddr != chain_rd_addr)
    ) else $error("chaining memory read and write to the same entry");

    // the round counter never runs past the last round
    a_round_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha1md_pkg::ST_ROUND) |-> (r_cnt <= LAST_ROUND)
    ) else $error("round counter out of range");

    // the buffer is never written while the schedule is being read out
    a_buf_quiet: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        msg_ctl.we |-> !msg_ctl.rd_en && !msg_ctl.shift_en
    ) else $error("block buffer written during compression");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // sha-1 start values and round constants
    localparam logic [159:0] SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                       32'h10325476, 32'hC3D2E1F0};
    localparam logic [31:0] RC_0 = 32'h5A827999;
    localparam logic [31:0] RC_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RC_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RC_3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    localparam int RANDOM_ITEMS = 115;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_has_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_message_digest_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // running hash state of the message being absorbed
    logic [31:0] chain_h [5];
    logic [7:0]  msg_blk [64];
    int          blk_fill;
    logic [63:0] msg_bits;

    // digest words still owed by the core, oldest first
    t_digest_word pending_digest [$];
    t_digest_word want;

    int  err_count;
    int  items_sent;
    int  bytes_sent;
    int  msgs_closed;
    int  words_checked;
    bit  src_gaps;
    bit  sink_gaps;

    always #4 i_clk = ~i_clk;

    function automatic void sha1_restart();
        int i;
        for (i = 0; i < 5; i++)
            chain_h[i] = SHA_IV[159 - 32 * i -: 32];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    // one 80-round compression of msg_blk into chain_h
    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {msg_blk[4 * i], msg_blk[4 * i + 1], msg_blk[4 * i + 2], msg_blk[4 * i + 3]};
        for (i = 16; i < 80; i++) begin
            t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
            w[i] = {t[30:0], t[31]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = RC_0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = RC_1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RC_2;
            end else begin
                f = b ^ c ^ d;
                k = RC_3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // absorb one accepted request; a close queues the five digest words
    function automatic void sha1_absorb(input logic [7:0] d, input logic has,
                                        input logic last);
        t_digest_word entry;
        int i;
        if (has) begin
            msg_blk[blk_fill] = d;
            blk_fill++;
            msg_bits += 64'd8;
            if (blk_fill == 64) begin
                sha1_compress();
                blk_fill = 0;
            end
        end
        if (last) begin
            msg_blk[blk_fill] = PAD_MARK;
            blk_fill++;
            // no room for the length: spill into an extra block
            if (blk_fill > 56) begin
                while (blk_fill < 64) begin
                    msg_blk[blk_fill] = 8'h00;
                    blk_fill++;
                end
                sha1_compress();
                blk_fill = 0;
            end
            while (blk_fill < 56) begin
                msg_blk[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (i = 0; i < 8; i++)
                msg_blk[63 - i] = msg_bits[8 * i +: 8];
            sha1_compress();
            for (i = 0; i < 5; i++) begin
                entry.word = chain_h[i];
                entry.idx  = 3'(i);
                entry.last = (i == 4);
                pending_digest.push_back(entry);
            end
            msgs_closed++;
            sha1_restart();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t mismatch: %s got %h wanted %h", $realtime, what, got, exp_val);
        err_count++;
    endtask

    // digest word checker, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, '0);
            end else begin
                want = pending_digest.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest word", o_digest_word, want.word);
                if (o_word_index !== want.idx)
                    report_mismatch("word index", 32'(o_word_index), 32'(want.idx));
                if (o_last_word !== want.last)
                    report_mismatch("last word flag", 32'(o_last_word), 32'(want.last));
                words_checked++;
            end
        end
    end

    // consumer back-pressure in random bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_gaps && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // drive one request and hold it until the core takes it
    task automatic send_request(input logic [7:0] d, input logic has, input logic last);
        @(negedge i_clk);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_has_byte  <= has;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sha1_absorb(d, has, last);
        items_sent++;
        if (has)
            bytes_sent++;
    endtask

    task automatic bus_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_for_digests();
        while (pending_digest.size() != 0) @(posedge i_clk);
    endtask

    // a message of len random bytes, closed on the last byte or by a separate empty close
    task automatic send_message(input int len, input bit split_close, input bit noise);
        int i;
        for (i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (i == len - 1) && !split_close);
        end
        if (len == 0 || split_close)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // empty message right after reset, preceded by an idle request
    task automatic test_empty_message();
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_short_text();
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
    endtask

    // all-zero and all-one bytes, idle in the middle, empty close after data
    task automatic test_byte_extremes();
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
    endtask

    // sender holds off until every digest word is out, then resumes with the next message
    task automatic test_pause_for_digest();
        send_message(3, 1'b0, 1'b0);
        bus_idle();
        wait_for_digests();
        send_message(2, 1'b1, 1'b0);
    endtask

    // mostly short messages, some at the padding and block boundaries
    task automatic test_random_messages();
        int start_count;
        int len;
        int remaining;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 8))
                    0: len = 54;
                    1: len = 55;
                    2: len = 56;
                    3: len = 57;
                    4: len = 63;
                    5: len = 64;
                    6: len = 65;
                    7: len = 119;
                    default: len = 120;
                endcase
            end else begin
                len = $urandom_range(0, 12);
            end
            // keep the request budget
            remaining = RANDOM_ITEMS - (items_sent - start_count);
            if (len > remaining)
                len = remaining;
            send_message(len, $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    // full rate on both sides to close the run
    task automatic test_back_to_back();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_message(64, 1'b0, 1'b0);
        send_message(55, 1'b0, 1'b0);
        send_message(0, 1'b1, 1'b0);
        send_message(56, 1'b1, 1'b0);
        send_message(1, 1'b0, 1'b0);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_has_byte    = 1'b0;
        i_last_byte   = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        bytes_sent    = 0;
        msgs_closed   = 0;
        words_checked = 0;
        src_gaps      = 1'b0;
        sink_gaps     = 1'b0;
        sha1_restart();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_short_text();
        test_byte_extremes();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        test_pause_for_digest();
        test_random_messages();
        test_back_to_back();

        bus_idle();
        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, %0d requests in all",
                 msgs_closed, bytes_sent, items_sent);
        $display("checked %0d digest words, %0d mismatches", words_checked, err_count);
        if (err_count == 0 && pending_digest.size() == 0)
            $display("sha1_message_digest_core regression: pass");
        else
            $display("sha1_message_digest_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("sha1_message_digest_core regression: fail");
        $finish;
    end

endmodule
